>>> rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Shared widths, operation and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int WORD_W       = 32;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_LEFT    = 3'd0,
    KIND_PUSH_RIGHT   = 3'd1,
    KIND_POP_LEFT     = 3'd2,
    KIND_POP_RIGHT    = 3'd3,
    KIND_CURSOR_LEFT  = 3'd4,
    KIND_CURSOR_RIGHT = 3'd5,
    KIND_SET_CURSOR   = 3'd6,
    KIND_QUERY        = 3'd7
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_END   = 2'd3
  } status_t;

  // Control broadcast to one cell of the word chain.
  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic load;
  } cell_ctrl_t;

endpackage

>>> rtl/core/dq_in_if.sv
// ----------------------------------------------------------------------------
// Deque command channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface dq_in_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);

endinterface

>>> rtl/core/dq_out_if.sv
// ----------------------------------------------------------------------------
// Deque result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface dq_out_if #(
  parameter int COUNT_W = 5
);
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] popped_value;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;
  logic signed [WORD_W-1:0] left_value;
  logic signed [WORD_W-1:0] right_value;
  logic signed [WORD_W-1:0] cursor_value;
  logic                     is_empty;

  modport source (output valid, output popped_value, output status, output count,
                  output left_value, output right_value, output cursor_value,
                  output is_empty, input ready);
  modport sink   (input valid, input popped_value, input status, input count,
                  input left_value, input right_value, input cursor_value,
                  input is_empty, output ready);

endinterface

>>> rtl/core/dq_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One word of the chain: holds, takes a neighbour's word or loads a new word.
// ----------------------------------------------------------------------------
module dq_cell (
  input  logic                      clk,
  input  dq_pkg::cell_ctrl_t        ctrl,
  input  logic [dq_pkg::WORD_W-1:0] value,
  input  logic [dq_pkg::WORD_W-1:0] left_word,
  input  logic [dq_pkg::WORD_W-1:0] right_word,
  output logic [dq_pkg::WORD_W-1:0] word
);
  import dq_pkg::*;

  logic [WORD_W-1:0] word_next;

  always_comb begin
    if (ctrl.shift_right) begin
      word_next = left_word;
    end else if (ctrl.shift_left) begin
      word_next = right_word;
    end else if (ctrl.load) begin
      word_next = value;
    end else begin
      word_next = word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

>>> rtl/core/dq_read.sv
// ----------------------------------------------------------------------------
// Deque read port
// Selects the word of the chain at a logical position.
// ----------------------------------------------------------------------------
module dq_read #(
  parameter int CAPACITY = dq_pkg::DEF_CAPACITY
) (
  input  logic [dq_pkg::WORD_W-1:0]   words [CAPACITY],
  input  logic [$clog2(CAPACITY)-1:0] index,
  output logic [dq_pkg::WORD_W-1:0]   word
);
  import dq_pkg::*;

  // Positions past the last cell only arise when the deque is empty.
  always_comb begin
    if (int'(index) < CAPACITY) begin
      word = words[index];
    end else begin
      word = '0;
    end
  end

endmodule

>>> rtl/core/deque_with_cursor.sv
// ----------------------------------------------------------------------------
// Double-ended queue with cursor
// Bounded deque of 32-bit words kept in a chain of cells, leftmost word in
// cell 0, with a cursor position and one result item for every command.
// ----------------------------------------------------------------------------
//  Channel | Role   | Payload
//  cmd     | sink   | kind, value
//  res     | source | popped_value, status, count, left_value, right_value,
//          |        | cursor_value, is_empty
//
// The cells shift or load on the edge that accepts an item, and the result
// register loads from the updated chain when it is empty or being read.
// A new item is taken while the previous result still waits in the result
// register; only the single pending stage between the two holds off input.
// Reset clears the count, the cursor and the handshake flags; cells keep
// whatever they held, as no word beyond the count is ever shown.
// ----------------------------------------------------------------------------
module deque_with_cursor #(
  parameter int CAPACITY = dq_pkg::DEF_CAPACITY
) (
  input  logic     clk,
  input  logic     rst,
  dq_in_if.sink    cmd,
  dq_out_if.source res
);
  import dq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [WORD_W-1:0] words [CAPACITY];
  cell_ctrl_t        ctrl [CAPACITY];

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [IW-1:0] cur_pos;
  logic [IW-1:0] cur_pos_next;

  logic                pend_valid;
  logic [WORD_W-1:0]   pend_popped;
  logic [STATUS_W-1:0] pend_status;

  logic                out_valid;
  logic [WORD_W-1:0]   out_popped;
  logic [STATUS_W-1:0] out_status;
  logic [CW-1:0]       out_count;
  logic [WORD_W-1:0]   out_left;
  logic [WORD_W-1:0]   out_right;
  logic [WORD_W-1:0]   out_cursor;
  logic                out_empty;

  logic                accept;
  logic                empty;
  logic                full;
  logic [CW-1:0]       count_m1;
  logic [IW-1:0]       right_pos;
  logic                at_left;
  logic                at_right;
  logic [WORD_W-1:0]   right_word;
  logic [WORD_W-1:0]   cursor_word;
  logic [WORD_W-1:0]   value_u;
  logic                shr;
  logic                shl;
  logic                load_en;
  logic [IW-1:0]       load_pos;
  logic [WORD_W-1:0]   popped;
  logic [STATUS_W-1:0] status;
  logic                out_load;

  assign accept    = cmd.valid & cmd.ready;
  assign cmd.ready = ~pend_valid;
  assign value_u   = $unsigned(cmd.value);

  assign empty     = (count == '0);
  assign full      = (count == CW'(CAPACITY));
  assign count_m1  = count - CW'(1);
  assign right_pos = count_m1[IW-1:0];
  assign at_left   = (cur_pos == '0);
  assign at_right  = (cur_pos == right_pos);

  dq_read #(.CAPACITY(CAPACITY)) u_read_right (
    .words (words),
    .index (right_pos),
    .word  (right_word)
  );

  dq_read #(.CAPACITY(CAPACITY)) u_read_cursor (
    .words (words),
    .index (cur_pos),
    .word  (cursor_word)
  );

  always_comb begin
    count_next   = count;
    cur_pos_next = cur_pos;
    popped       = '0;
    status       = ST_OK;
    shr          = 1'b0;
    shl          = 1'b0;
    load_en      = 1'b0;
    load_pos     = count[IW-1:0];
    case (kind_t'(cmd.kind))
      KIND_PUSH_LEFT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          shr          = 1'b1;
          count_next   = count + CW'(1);
          cur_pos_next = empty ? '0 : cur_pos + IW'(1);
        end
      end
      KIND_PUSH_RIGHT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          load_en      = 1'b1;
          count_next   = count + CW'(1);
          cur_pos_next = empty ? '0 : cur_pos;
        end
      end
      KIND_POP_LEFT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          // The cursor follows its word, or stays on the new leftmost one.
          popped       = words[0];
          shl          = 1'b1;
          count_next   = count_m1;
          cur_pos_next = at_left ? '0 : cur_pos - IW'(1);
        end
      end
      KIND_POP_RIGHT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          popped     = right_word;
          count_next = count_m1;
          if (at_right) begin
            cur_pos_next = at_left ? '0 : cur_pos - IW'(1);
          end
        end
      end
      KIND_CURSOR_LEFT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (at_left) begin
          status = ST_END;
        end else begin
          cur_pos_next = cur_pos - IW'(1);
        end
      end
      KIND_CURSOR_RIGHT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (at_right) begin
          status = ST_END;
        end else begin
          cur_pos_next = cur_pos + IW'(1);
        end
      end
      KIND_SET_CURSOR: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          load_en  = 1'b1;
          load_pos = cur_pos;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_word;
    logic [WORD_W-1:0] right_nb;

    if (i == 0) begin : g_first
      assign left_word = value_u;
    end else begin : g_inner_l
      assign left_word = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_nb = words[i];
    end else begin : g_inner_r
      assign right_nb = words[i+1];
    end

    assign ctrl[i].shift_right = accept & shr;
    assign ctrl[i].shift_left  = accept & shl;
    assign ctrl[i].load        = accept & load_en & (load_pos == IW'(i));

    dq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .value      (value_u),
      .left_word  (left_word),
      .right_word (right_nb),
      .word       (words[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cur_pos <= '0;
    end else if (accept) begin
      count   <= count_next;
      cur_pos <= cur_pos_next;
    end
  end

  assign out_load = pend_valid & (~out_valid | res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (out_load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_popped <= popped;
      pend_status <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // The chain already holds the state after the pending item at this point.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_popped <= pend_popped;
      out_status <= pend_status;
      out_count  <= count;
      out_empty  <= empty;
      out_left   <= empty ? '0 : words[0];
      out_right  <= empty ? '0 : right_word;
      out_cursor <= empty ? '0 : cursor_word;
    end
  end

  assign res.valid        = out_valid;
  assign res.popped_value = $signed(out_popped);
  assign res.status       = out_status;
  assign res.count        = out_count;
  assign res.left_value   = $signed(out_left);
  assign res.right_value  = $signed(out_right);
  assign res.cursor_value = $signed(out_cursor);
  assign res.is_empty     = out_empty;

endmodule
